// ===== design/rme_pkg.sv =====
// shared types and constants for the modular exponentiation unit
// no dependencies

package rme_pkg;

   // width of the register and payload fields
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PUB_EXP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIV_EXP = 2'd2;

   // request types
   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // take a new beat and start base reduction
      logic mul_acc;    // product = acc * base
      logic mul_sq;     // product = base * base
      logic red_step;   // one restoring reduction step
      logic wr_acc;     // last reduction step lands in acc
      logic wr_base;    // last reduction step lands in base
      logic exp_shift;  // drop the exponent lsb
      logic finish;     // capture the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic red_last;   // reduction on its last step
      logic exp_zero;   // exponent exhausted
      logic exp_lsb;    // current exponent bit
      logic exp_last;   // only the lsb may still be set
   } sts_type;

endpackage

// ===== design/rme_datapath.sv =====
// datapath: operand registers, multiplier and bit-serial modular reduction
// depends on rme_pkg

module rme_datapath import rme_pkg::*; #(
   parameter int unsigned WIDTH = 32
) (
   input  logic               clock,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [WIDTH-1:0]   modulus,
   input  logic [FIELD_W-1:0] pub_exp,
   input  logic [FIELD_W-1:0] priv_exp,
   input  logic               req_type,
   input  logic [FIELD_W-1:0] block_value,
   output logic [FIELD_W-1:0] result_value
);

   localparam int unsigned RW = (2 * WIDTH > FIELD_W) ? 2 * WIDTH : FIELD_W;
   localparam int unsigned CW = $clog2(RW);
   localparam logic [CW-1:0] CNT_LAST = CW'(RW - 1);

   logic [WIDTH-1:0]   acc_ff, acc_in;
   logic [WIDTH-1:0]   base_ff, base_in;
   logic [FIELD_W-1:0] exp_ff, exp_in;
   logic [RW-1:0]      prod_ff, prod_in;
   logic [WIDTH:0]     rem_ff, rem_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [FIELD_W-1:0] result_ff, result_in;
   logic [WIDTH:0]     rem_shift;
   logic [2*WIDTH-1:0] mul_a, mul_b;
   logic               mod_zero;

   assign mod_zero = (modulus == '0);

   // one restoring step: shift in the next product bit, subtract if not below
   always_comb begin
      rem_shift = {rem_ff[WIDTH-1:0], prod_ff[RW-1]};
      if (rem_shift >= {1'b0, modulus}) begin
         rem_in = rem_shift - {1'b0, modulus};
      end else begin
         rem_in = rem_shift;
      end
   end

   assign mul_a = {{WIDTH{1'b0}}, acc_ff} * {{WIDTH{1'b0}}, base_ff};
   assign mul_b = {{WIDTH{1'b0}}, base_ff} * {{WIDTH{1'b0}}, base_ff};

   // next values
   always_comb begin
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      if (cmd.load) begin
         acc_in  = WIDTH'(1);
         exp_in  = (req_type == REQ_DECRYPT) ? priv_exp : pub_exp;
         prod_in = RW'(block_value);
         cnt_in  = '0;
      end
      if (cmd.mul_acc) begin
         prod_in = RW'(mul_a);
         cnt_in  = '0;
      end
      if (cmd.mul_sq) begin
         prod_in = RW'(mul_b);
         cnt_in  = '0;
      end
      if (cmd.red_step) begin
         prod_in = {prod_ff[RW-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.wr_acc) begin
         acc_in = rem_in[WIDTH-1:0];
      end
      if (cmd.wr_base) begin
         base_in = rem_in[WIDTH-1:0];
      end
      if (cmd.exp_shift) begin
         exp_in = {1'b0, exp_ff[FIELD_W-1:1]};
      end
      if (cmd.finish) begin
         result_in = mod_zero ? '0 : FIELD_W'(acc_ff);
      end
   end

   // operand registers, remainder cleared at each new reduction
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      if (cmd.load || cmd.mul_acc || cmd.mul_sq) begin
         rem_ff <= '0;
      end else if (cmd.red_step) begin
         rem_ff <= rem_in;
      end
   end

   assign sts.red_last = (cnt_ff == CNT_LAST);
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_lsb  = exp_ff[0];
   assign sts.exp_last = (exp_ff[FIELD_W-1:1] == '0);
   assign result_value = result_ff;

endmodule

// ===== design/rme_controller.sv =====
// controller: sequences reductions, multiplies and the output handshake
// depends on rme_pkg

module rme_controller import rme_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RED, ST_STEP, ST_SQ, ST_FINISH
   } state_type;

   typedef enum logic [0:0] {
      TGT_BASE, TGT_ACC
   } target_type;

   state_type  state_ff, state_in;
   target_type tgt_ff, tgt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               tgt_in   = TGT_BASE;
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            if (sts.red_last) begin
               if (tgt_ff == TGT_ACC) begin
                  cmd.wr_acc = 1'b1;
                  state_in   = ST_SQ;
               end else begin
                  cmd.wr_base = 1'b1;
                  state_in    = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (sts.exp_zero) begin
               state_in = ST_FINISH;
            end else if (sts.exp_lsb) begin
               cmd.mul_acc = 1'b1;
               tgt_in      = TGT_ACC;
               state_in    = ST_RED;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.exp_shift = 1'b1;
            if (sts.exp_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_sq = 1'b1;
               tgt_in     = TGT_BASE;
               state_in   = ST_RED;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tgt_ff       <= TGT_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/rsa_modular_exponentiation_unit.sv =====
// Modular exponentiation unit: one beat in gives block_value to the public
// (encrypt) or private (decrypt) exponent modulo the modulus, by right-to-left
// square-and-multiply. Every modular product goes through a bit-serial
// restoring reduction over max(2*WIDTH, 32) product bits. One item is worked
// at a time; the result register lets the next beat enter while a result
// waits. Registers are to be written by the user only while no item is in
// flight; the block itself does not enforce it.
// depends on rme_pkg, rme_controller, rme_datapath

module rsa_modular_exponentiation_unit import rme_pkg::*; #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [FIELD_W-1:0]   req_block_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FIELD_W-1:0]   rsp_result_value,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_data
);

   logic [FIELD_W-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;
   cmd_type cmd;
   sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= FIELD_W'(1);
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_ff  <= csr_data;
            CSR_PUB_EXP:  pub_exp_ff  <= csr_data;
            CSR_PRIV_EXP: priv_exp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rme_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rme_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .sts          (sts),
      .modulus      (modulus_ff[WIDTH-1:0]),
      .pub_exp      (pub_exp_ff),
      .priv_exp     (priv_exp_ff),
      .req_type     (req_type),
      .block_value  (req_block_value),
      .result_value (rsp_result_value)
   );

`ifndef SYNTHESIS
   // one item in flight: accepting a beat closes the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // a result is below the modulus, is the one of a zero exponent, or is zero
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |->
         (rsp_result_value < FIELD_W'(modulus_ff[WIDTH-1:0])) ||
         (rsp_result_value == FIELD_W'(1)) || (rsp_result_value == '0))
      else $error("result out of range");

   // a new result appears only as the input side reopens
   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while busy");
`endif

endmodule

// ===== verif/rme_checker.sv =====
// result checker for the modular exponentiation unit: predicts each result
// and compares it with what the unit returns
// depends on rme_pkg

module rme_checker import rme_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic [FIELD_W-1:0] req_block_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [FIELD_W-1:0] rsp_result_value,
   input  logic               csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0] csr_data,
   output int                 in_flight,
   output int                 fail_count
);

   // shadow copy of the register file
   logic [FIELD_W-1:0] modulus_q;
   logic [FIELD_W-1:0] pub_exp_q;
   logic [FIELD_W-1:0] priv_exp_q;

   // powers still owed by the unit, oldest first
   logic [FIELD_W-1:0] owed_powers[$];

   // right-to-left square-and-multiply
   function automatic logic [FIELD_W-1:0] mod_power(input logic [FIELD_W-1:0] base_v,
                                                    input logic [FIELD_W-1:0] expo,
                                                    input logic [FIELD_W-1:0] modv);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] mm;
      if (modv == '0) return '0;
      mm = {32'd0, modv};
      sq = {32'd0, base_v} % mm;
      acc = 64'd1;
      for (int i = 0; i < FIELD_W; i++) begin
         if (expo[i]) acc = (acc * sq) % mm;
         sq = (sq * sq) % mm;
      end
      return acc[FIELD_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("checker: %s at %0t", what, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [FIELD_W-1:0] want;
      if (reset) begin
         modulus_q  <= 32'd1;
         pub_exp_q  <= '0;
         priv_exp_q <= '0;
         in_flight  <= 0;
         owed_powers.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_MODULUS:  modulus_q  <= csr_data;
               CSR_PUB_EXP:  pub_exp_q  <= csr_data;
               CSR_PRIV_EXP: priv_exp_q <= csr_data;
               default: ;
            endcase
         end
         // request beat: predict
         if (req_valid && req_ready)
            owed_powers.push_back(mod_power(req_block_value,
               (req_type == REQ_DECRYPT) ? priv_exp_q : pub_exp_q, modulus_q));
         // result beat: compare
         if (rsp_valid && rsp_ready) begin
            if (owed_powers.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = owed_powers.pop_front();
               if (rsp_result_value !== want)
                  report_mismatch($sformatf("result_value %h, expected %h",
                                            rsp_result_value, want));
            end
         end
         in_flight <= in_flight + ((req_valid && req_ready) ? 1 : 0)
                                - ((rsp_valid && rsp_ready) ? 1 : 0);
      end
   end

endmodule

// ===== verif/rsa_modular_exponentiation_unit_test.sv =====
// stimulus and verdict for the modular exponentiation unit: register
// settings, request beats and result back-pressure
// depends on rme_pkg, rsa_modular_exponentiation_unit, rme_checker

module rsa_modular_exponentiation_unit_test;
   import rme_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int HOLD_CYCLES = 15000;
   localparam int HOLD_AT = 100;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_type;
   logic [FIELD_W-1:0] req_block_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [FIELD_W-1:0] rsp_result_value;
   logic               csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0] csr_data;
   int                 in_flight;
   int                 fail_count;
   int                 cycles;
   int                 results_taken;
   logic [FIELD_W-1:0] cur_modulus;
   bit                 no_gaps;

   rsa_modular_exponentiation_unit u_dut (.*);

   rme_checker u_checker (.*);

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cycle limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off
   initial begin
      int w;
      rsp_ready = 1'b0;
      results_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = (results_taken == HOLD_AT) ? HOLD_CYCLES
             : (no_gaps ? 0 : $urandom_range(0, 7));
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         results_taken++;
      end
   end

   // program all three registers, optionally with a stray write first
   task automatic set_regs(input logic [FIELD_W-1:0] modv,
                           input logic [FIELD_W-1:0] pub,
                           input logic [FIELD_W-1:0] priv,
                           input bit stray);
      if (stray) begin
         csr_write <= 1'b1;
         csr_index <= CSR_SPARE;
         csr_data  <= $urandom;
         @(posedge clock);
      end
      csr_write <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_data  <= modv;
      @(posedge clock);
      csr_index <= CSR_PUB_EXP;
      csr_data  <= pub;
      @(posedge clock);
      csr_index <= CSR_PRIV_EXP;
      csr_data  <= priv;
      @(posedge clock);
      csr_write <= 1'b0;
      cur_modulus = modv;
      @(posedge clock);
   endtask

   // one request beat, preceded by a random gap
   task automatic send_beat(input logic kind, input logic [FIELD_W-1:0] value);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_block_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // close a phase: lower valid and wait for every result
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return cur_modulus - 1;
         3: return cur_modulus;
         4: return cur_modulus + 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_exponent(input bit full);
      if (full || $urandom_range(0, 4) == 0) return $urandom;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'd1;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(2, 1000);
         2: return 32'h8000_0000 | $urandom;
         3: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_ENCRYPT;
      req_block_value = '0;
      csr_write = 1'b0;
      csr_index = CSR_MODULUS;
      csr_data = '0;
      cur_modulus = 32'd1;
      no_gaps = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero exponents give one
      send_beat(REQ_ENCRYPT, '0);
      send_beat(REQ_DECRYPT, '1);
      send_beat(REQ_ENCRYPT, 32'h1234_5678);
      drain();

      // zero modulus gives zero whatever the exponent; stray index ignored
      set_regs('0, 32'd7, '0, 1'b1);
      send_beat(REQ_ENCRYPT, 32'd5);
      send_beat(REQ_DECRYPT, '1);
      drain();

      // modulus one: zero unless the exponent is zero
      set_regs(32'd1, 32'd5, '0, 1'b0);
      send_beat(REQ_ENCRYPT, 32'd9);
      send_beat(REQ_DECRYPT, 32'd9);
      send_beat(REQ_ENCRYPT, '1);
      drain();

      // widest modulus and public exponent, base at and below the modulus
      set_regs('1, '1, 32'd1, 1'b0);
      send_beat(REQ_ENCRYPT, '1);
      send_beat(REQ_DECRYPT, '1);
      send_beat(REQ_DECRYPT, 32'hFFFF_FFFE);
      send_beat(REQ_ENCRYPT, 32'd2);
      send_beat(REQ_DECRYPT, '0);
      drain();

      // small modulus, textbook key
      set_regs(32'd3233, 32'd17, 32'd2753, 1'b0);
      send_beat(REQ_ENCRYPT, 32'd65);
      send_beat(REQ_DECRYPT, 32'd2790);
      send_beat(REQ_ENCRYPT, 32'd3233);
      send_beat(REQ_DECRYPT, 32'd3300);
      send_beat(REQ_ENCRYPT, '1);
      drain();

      // random phases, some without gaps
      for (int p = 0; p < 12; p++) begin
         no_gaps = (p % 4 == 3);
         set_regs(pick_modulus(), pick_exponent(p == 11), pick_exponent(p == 11),
                  $urandom_range(0, 3) == 0);
         for (int k = 0; k < ((p == 11) ? 12 : 21); k++)
            send_beat(1'($urandom_range(0, 1)), pick_value());
         drain();
      end
      no_gaps = 1'b0;

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
